// ===== sv/pjhm_pkg.sv =====
package pjhm_pkg;

	// Default geometry of the deviation histogram
	localparam int unsigned NUM_BINS_DEF     = 64;
	localparam int unsigned BIN_WIDTH_US_DEF = 10;

	// Field widths
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned TIME_W    = 24;
	localparam int unsigned NOM_W     = 20;
	localparam int unsigned TENTHS_W  = 10;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned SUM_W     = 56;
	localparam int unsigned PCT_W     = 16;

	// Percentile scale (tenths of a percent per whole)
	localparam int unsigned PCT_SCALE = 1000;

	localparam logic [NOM_W-1:0] NOM_RESET = NOM_W'(10000);

	// Commands
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [TIME_W-1:0]   loop_period;
		logic [TIME_W-1:0]   exec_time;
		logic [TENTHS_W-1:0] percentile_tenths;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]  sample_count;
		logic [TIME_W-1:0] period_lo;
		logic [TIME_W-1:0] period_hi;
		logic [SUM_W-1:0]  period_total_us;
		logic [TIME_W-1:0] exec_hi;
		logic [CNT_W-1:0]  overrun_count;
		logic [CNT_W-1:0]  overflow_count;
		logic [PCT_W-1:0]  percentile_us;
	} out_item_t;

endpackage

// ===== sv/period_jitter_histogram_monitor_core.sv =====
// Add: a reciprocal multiply gives the bin index, then a read-modify-write of the bin; a
// deviation past the last bin skips both. Clear and the unused command go straight to the
// result; a query with no samples skips the walk. Otherwise one histogram read a cycle
// feeds a scale-and-accumulate pipeline. One item at a time; a result not yet taken holds
// the last cycle. Reset (arst_n low) clears all statistics and bin valid bits at once and
// loads the nominal period with 10000; no clearing pass follows.
module period_jitter_histogram_monitor_core
	import pjhm_pkg::*;
#(
	parameter int unsigned NUM_BINS     = NUM_BINS_DEF,
	parameter int unsigned BIN_WIDTH_US = BIN_WIDTH_US_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [NOM_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item
);

	localparam int unsigned BIN_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int unsigned RADDR_W  = BIN_W + 1;
	localparam int unsigned DEV_LIM  = NUM_BINS * BIN_WIDTH_US;
	localparam int unsigned REM_W    = (DEV_LIM > 1) ? $clog2(DEV_LIM) : 1;
	localparam int unsigned RCP_L    = $clog2(BIN_WIDTH_US);
	localparam int unsigned RCP_S    = REM_W + RCP_L;
	localparam longint unsigned RCP_M =
		((64'd1 << RCP_S) + 64'(BIN_WIDTH_US) - 64'd1) / 64'(BIN_WIDTH_US);
	localparam int unsigned MUL_W    = 2 * REM_W + 1;
	localparam int unsigned PROD_W   = CNT_W + TENTHS_W;
	localparam int unsigned ACC_W    = CNT_W + BIN_W + TENTHS_W + 1;
	localparam int unsigned EDGE_W0  = $clog2(DEV_LIM + 1);
	localparam int unsigned EDGE_W   = (EDGE_W0 > PCT_W) ? EDGE_W0 : PCT_W + 1;
	localparam logic [PCT_W-1:0] PCT_FULL =
		(DEV_LIM > 65535) ? {PCT_W{1'b1}} : PCT_W'(DEV_LIM);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADD  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_INC  = 3'd4;
	localparam logic [2:0] S_QMUL = 3'd5;
	localparam logic [2:0] S_WALK = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0]          state_q;
	in_item_t            item_q;
	logic [NOM_W-1:0]    nom_q;

	// Statistics
	logic [CNT_W-1:0]    samples_q;
	logic [SUM_W-1:0]    sum_q;
	logic [TIME_W-1:0]   min_q;
	logic [TIME_W-1:0]   max_q;
	logic [TIME_W-1:0]   exec_max_q;
	logic [CNT_W-1:0]    overruns_q;
	logic [CNT_W-1:0]    overflows_q;

	// Histogram memory with per-bin valid bits
	logic [CNT_W-1:0]    hist_mem [NUM_BINS];
	logic [NUM_BINS-1:0] hvalid_q;
	logic [BIN_W-1:0]    rd_addr;
	logic [CNT_W-1:0]    rd_data_s1;
	logic                hv_s1;

	// Bin index by reciprocal multiply
	logic [REM_W-1:0]    dev_q;
	logic [BIN_W-1:0]    quo_q;
	logic [MUL_W-1:0]    quo_prod;

	// Percentile walk
	logic [PROD_W-1:0]   target_q;
	logic [RADDR_W-1:0]  raddr_q;
	logic                v_s1;
	logic [BIN_W-1:0]    idx_s1;
	logic                v_s2;
	logic [BIN_W-1:0]    idx_s2;
	logic [PROD_W-1:0]   prod_s2;
	logic [ACC_W-1:0]    acc_q;
	logic [ACC_W-1:0]    acc_next;
	logic [EDGE_W-1:0]   edge_us;
	logic [PCT_W-1:0]    edge_sat;
	logic [PCT_W-1:0]    pct_q;

	// Add datapath
	logic [TIME_W-1:0]   nom_ext;
	logic [TIME_W-1:0]   dev;
	logic                dev_ovf;
	logic [SUM_W:0]      sum_ext;
	logic [CNT_W-1:0]    bin_cur;

	out_item_t           out_q;
	logic                out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Deviation from nominal and the running sum
	assign nom_ext = TIME_W'(nom_q);
	assign dev     = (item_q.loop_period >= nom_ext) ? item_q.loop_period - nom_ext
	                                                 : nom_ext - item_q.loop_period;
	assign dev_ovf = (dev >= TIME_W'(DEV_LIM));
	assign sum_ext = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(item_q.loop_period);

	// Exact floor of deviation over bin width for deviations below the last bin edge
	assign quo_prod = MUL_W'(dev_q) * MUL_W'(RCP_M);

	// Bin read-modify-write
	assign bin_cur = hv_s1 ? rd_data_s1 : '0;

	// Scaled cumulative count against tenths * samples
	assign acc_next = acc_q + ACC_W'(prod_s2);
	assign edge_us  = (EDGE_W'(idx_s2) + EDGE_W'(1)) * EDGE_W'(BIN_WIDTH_US);
	assign edge_sat = (edge_us > EDGE_W'({PCT_W{1'b1}})) ? {PCT_W{1'b1}} : edge_us[PCT_W-1:0];

	assign rd_addr = (state_q == S_WALK) ? raddr_q[BIN_W-1:0] : quo_q;

	// Read the histogram every cycle
	always_ff @(posedge clk) begin
		rd_data_s1 <= hist_mem[rd_addr];
		hv_s1      <= hvalid_q[rd_addr];
		if (state_q == S_INC) begin
			hist_mem[quo_q] <= (bin_cur == {CNT_W{1'b1}}) ? bin_cur : bin_cur + CNT_W'(1);
		end
	end

	// Hold payload-only registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end
		idx_s1  <= raddr_q[BIN_W-1:0];
		idx_s2  <= idx_s1;
		prod_s2 <= PROD_W'(bin_cur) * PROD_W'(PCT_SCALE);
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_q <= NOM_RESET;
		end else if (cfg_wen) begin
			nom_q <= cfg_wdata;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			samples_q   <= '0;
			sum_q       <= '0;
			min_q       <= '1;
			max_q       <= '0;
			exec_max_q  <= '0;
			overruns_q  <= '0;
			overflows_q <= '0;
			hvalid_q    <= '0;
			dev_q       <= '0;
			quo_q       <= '0;
			target_q    <= '0;
			raddr_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			acc_q       <= '0;
			pct_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// Drop the result once taken, unless a new one loads now
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pct_q <= '0;
						unique case (in_item.command)
							CMD_ADD:   state_q <= S_ADD;
							CMD_QUERY: state_q <= S_QMUL;
							default:   state_q <= S_DONE;
						endcase
						if (in_item.command == CMD_CLEAR) begin
							samples_q   <= '0;
							sum_q       <= '0;
							min_q       <= '1;
							max_q       <= '0;
							exec_max_q  <= '0;
							overruns_q  <= '0;
							overflows_q <= '0;
							hvalid_q    <= '0;
						end
					end
				end

				S_ADD: begin
					// Update scalar statistics and hold the deviation
					if (samples_q != {CNT_W{1'b1}}) samples_q <= samples_q + CNT_W'(1);
					sum_q <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
					if (item_q.loop_period < min_q) min_q <= item_q.loop_period;
					if (item_q.loop_period > max_q) max_q <= item_q.loop_period;
					if (item_q.exec_time > exec_max_q) exec_max_q <= item_q.exec_time;
					if (item_q.exec_time > nom_ext && overruns_q != {CNT_W{1'b1}}) begin
						overruns_q <= overruns_q + CNT_W'(1);
					end
					dev_q <= REM_W'(dev);
					if (dev_ovf) begin
						if (overflows_q != {CNT_W{1'b1}}) overflows_q <= overflows_q + CNT_W'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end

				S_DIV: begin
					// Take the bin index from the scaled product
					quo_q   <= BIN_W'(quo_prod >> RCP_S);
					state_q <= S_RD;
				end

				S_RD: begin
					state_q <= S_INC;
				end

				S_INC: begin
					hvalid_q[quo_q] <= 1'b1;
					state_q         <= S_DONE;
				end

				S_QMUL: begin
					// Form tenths * samples and start the walk when there are samples
					target_q <= PROD_W'(item_q.percentile_tenths) * PROD_W'(samples_q);
					raddr_q  <= '0;
					v_s1     <= 1'b0;
					v_s2     <= 1'b0;
					acc_q    <= ACC_W'(PCT_SCALE);
					if (samples_q == '0) begin
						pct_q   <= '0;
						state_q <= S_DONE;
					end else begin
						pct_q   <= PCT_FULL;
						state_q <= S_WALK;
					end
				end

				S_WALK: begin
					// Advance the read address and the accumulate pipeline
					v_s1 <= (raddr_q < RADDR_W'(NUM_BINS));
					if (raddr_q < RADDR_W'(NUM_BINS)) raddr_q <= raddr_q + RADDR_W'(1);
					v_s2 <= v_s1;
					if (v_s2) begin
						acc_q <= acc_next;
						if (acc_next > ACC_W'(target_q)) begin
							pct_q   <= edge_sat;
							state_q <= S_DONE;
						end else if (idx_s2 == BIN_W'(NUM_BINS - 1)) begin
							state_q <= S_DONE;
						end
					end
				end

				S_DONE: begin
					// Load the result once the output register is free
					if (!out_valid_q || out_ready) begin
						out_q.sample_count    <= samples_q;
						out_q.period_lo       <= min_q;
						out_q.period_hi       <= max_q;
						out_q.period_total_us <= sum_q;
						out_q.exec_hi         <= exec_max_q;
						out_q.overrun_count   <= overruns_q;
						out_q.overflow_count  <= overflows_q;
						out_q.percentile_us   <= pct_q;
						out_valid_q           <= 1'b1;
						state_q               <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== verif/tb_period_jitter_histogram_monitor_core.sv =====
`timescale 1ns / 100ps

module tb_period_jitter_histogram_monitor_core;
	import pjhm_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned      PHASES     = 8;
	localparam int unsigned      PHASE_ITEMS = 240;
	localparam int unsigned      CALM_PHASE  = 3;
	localparam int unsigned      HOLD_PHASE  = 2;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wen = 1'b0;
	logic [NOM_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_item_t         in_item = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_item;

	// One row of the directed table; want is used only when typed is set
	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} probe_t;

	// Predictor state
	logic [CNT_W-1:0]  bin_count [NUM_BINS_DEF];
	logic [CNT_W-1:0]  n_samples;
	logic [SUM_W-1:0]  sum_periods;
	logic [TIME_W-1:0] lo_period;
	logic [TIME_W-1:0] hi_period;
	logic [TIME_W-1:0] hi_exec;
	logic [CNT_W-1:0]  n_overruns;
	logic [CNT_W-1:0]  n_overflows;
	logic [NOM_W-1:0]  nom_us;

	out_item_t   stats_due [$];
	probe_t      probes [$];
	int unsigned mismatches = 0;
	bit          calm = 1'b0;

	period_jitter_histogram_monitor_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #1 clk = ~clk;

	// End the run if the block hangs
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void clear_stats();
		foreach (bin_count[i]) bin_count[i] = '0;
		n_samples   = '0;
		sum_periods = '0;
		lo_period   = '1;
		hi_period   = '0;
		hi_exec     = '0;
		n_overruns  = '0;
		n_overflows = '0;
	endfunction

	function automatic out_item_t reset_view();
		out_item_t r;
		r = '0;
		r.period_lo = '1;
		return r;
	endfunction

	// Walk the cumulative bins until the target count is reached
	function automatic logic [PCT_W-1:0] query_percentile(logic [TENTHS_W-1:0] tenths);
		logic [63:0] target;
		logic [63:0] cum;
		logic [63:0] edge_us;
		if (n_samples == 0)
			return '0;
		target  = (64'(tenths) * 64'(n_samples)) / PCT_SCALE;
		cum     = '0;
		edge_us = 64'(NUM_BINS_DEF) * 64'(BIN_WIDTH_US_DEF);
		for (int i = 0; i < NUM_BINS_DEF; i++) begin
			cum += 64'(bin_count[i]);
			if (cum >= target) begin
				edge_us = 64'(i + 1) * 64'(BIN_WIDTH_US_DEF);
				break;
			end
		end
		return (edge_us > 64'hFFFF) ? 16'hFFFF : edge_us[PCT_W-1:0];
	endfunction

	// Apply one item to the predictor and return the statistics it reports
	function automatic out_item_t predict_stats(in_item_t it);
		logic [TIME_W-1:0] nom;
		logic [TIME_W-1:0] dev;
		int unsigned       bin;
		logic [SUM_W:0]    acc;
		out_item_t         r;
		r   = '0;
		nom = TIME_W'(nom_us);
		case (it.command)
			CMD_CLEAR: clear_stats();
			CMD_ADD: begin
				dev = (it.loop_period >= nom) ? it.loop_period - nom : nom - it.loop_period;
				bin = dev / BIN_WIDTH_US_DEF;
				if (bin < NUM_BINS_DEF)
					bin_count[bin] = sat_inc(bin_count[bin]);
				else
					n_overflows = sat_inc(n_overflows);
				n_samples = sat_inc(n_samples);
				acc = {1'b0, sum_periods} + (SUM_W+1)'(it.loop_period);
				sum_periods = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
				if (it.loop_period < lo_period) lo_period = it.loop_period;
				if (it.loop_period > hi_period) hi_period = it.loop_period;
				if (it.exec_time > hi_exec) hi_exec = it.exec_time;
				if (it.exec_time > nom) n_overruns = sat_inc(n_overruns);
			end
			CMD_QUERY: r.percentile_us = query_percentile(it.percentile_tenths);
			default: ;
		endcase
		r.sample_count    = n_samples;
		r.period_lo       = lo_period;
		r.period_hi       = hi_period;
		r.period_total_us = sum_periods;
		r.exec_hi         = hi_exec;
		r.overrun_count   = n_overruns;
		r.overflow_count  = n_overflows;
		return r;
	endfunction

	function automatic in_item_t mk(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] p,
			logic [TIME_W-1:0] e, logic [TENTHS_W-1:0] t);
		in_item_t it;
		it.command           = cmd;
		it.loop_period       = p;
		it.exec_time         = e;
		it.percentile_tenths = t;
		return it;
	endfunction

	// Random value near the nominal period, folded at zero
	function automatic logic [TIME_W-1:0] near_nom(int unsigned spread);
		int v;
		v = int'(nom_us) + int'($urandom_range(2 * spread)) - int'(spread);
		if (v < 0) v = -v;
		return TIME_W'(v);
	endfunction

	// Mostly well-formed adds around the nominal period, with queries, clears and noise
	function automatic in_item_t pick_item();
		in_item_t    it;
		int unsigned r;
		it = '0;
		it.percentile_tenths = TENTHS_W'($urandom_range(1023));
		r = $urandom_range(99);
		if (r < 3) begin
			it.command = CMD_CLEAR;
		end else if (r < 17) begin
			it.command = CMD_QUERY;
			if ($urandom_range(9) < 8)
				it.percentile_tenths = TENTHS_W'($urandom_range(PCT_SCALE));
		end else if (r < 87) begin
			it.command     = CMD_ADD;
			it.loop_period = near_nom(700);
			it.exec_time   = ($urandom_range(9) == 0) ? TIME_W'($urandom) : near_nom(60);
		end else begin
			it.command     = CMD_W'($urandom_range(3));
			it.loop_period = TIME_W'($urandom);
			it.exec_time   = TIME_W'($urandom);
		end
		return it;
	endfunction

	// Present one item and hold it until it is accepted; returns on a falling edge
	task automatic send_item(in_item_t it, bit typed, out_item_t want);
		out_item_t got;
		while (!calm && $urandom_range(99) < 37) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_item  = it;
		do @(posedge clk); while (!in_ready);
		got = predict_stats(it);
		stats_due.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	// Drop valid and hold until every expected item has come back
	task automatic drain();
		in_valid = 1'b0;
		while (stats_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_nominal(logic [NOM_W-1:0] v);
		drain();
		cfg_wen   = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_wen = 1'b0;
		nom_us  = v;
	endtask

	// Receiver stalls
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= 37);

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		out_item_t exp_item;
		if (arst_n && out_valid && out_ready) begin
			if (stats_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item at %0t: %p", $realtime, out_item);
			end else begin
				exp_item = stats_due.pop_front();
				if (out_item !== exp_item) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t", $realtime);
						$display("  count exp %h got %h  min exp %h got %h  max exp %h got %h",
							exp_item.sample_count, out_item.sample_count,
							exp_item.period_lo, out_item.period_lo,
							exp_item.period_hi, out_item.period_hi);
						$display("  total exp %h got %h  exec exp %h got %h",
							exp_item.period_total_us, out_item.period_total_us,
							exp_item.exec_hi, out_item.exec_hi);
						$display("  overrun exp %h got %h  overflow exp %h got %h",
							exp_item.overrun_count, out_item.overrun_count,
							exp_item.overflow_count, out_item.overflow_count);
						$display("  pct exp %h got %h",
							exp_item.percentile_us, out_item.percentile_us);
					end
				end
			end
		end
	end

	initial begin
		logic [NOM_W-1:0] settings [PHASES];
		out_item_t        first_add;
		out_item_t        none;
		probe_t           pr;

		none = '0;
		nom_us = NOM_RESET;
		clear_stats();

		// Directed table, at the reset nominal period of 10000
		first_add = reset_view();
		first_add.sample_count    = 1;
		first_add.period_lo       = 10000;
		first_add.period_hi       = 10000;
		first_add.period_total_us = 10000;
		first_add.exec_hi         = 10000;
		probes.push_back('{mk(CMD_QUERY, 0, 0, 500), 1'b1, reset_view()});
		probes.push_back('{mk(CMD_QUERY, 0, 0, 1023), 1'b1, reset_view()});
		probes.push_back('{mk(CMD_UNUSED, '1, '1, '1), 1'b1, reset_view()});
		probes.push_back('{mk(CMD_ADD, 10000, 10000, 0), 1'b1, first_add});
		probes.push_back('{mk(CMD_QUERY, 0, 0, 1000), 1'b0, none});
		probes.push_back('{mk(CMD_ADD, 0, '1, '1), 1'b0, none});
		probes.push_back('{mk(CMD_ADD, '1, 0, 0), 1'b0, none});
		probes.push_back('{mk(CMD_ADD, 10639, 10001, 0), 1'b0, none});
		probes.push_back('{mk(CMD_ADD, 9360, 9999, 0), 1'b0, none});
		probes.push_back('{mk(CMD_ADD, 10009, 0, 0), 1'b0, none});
		probes.push_back('{mk(CMD_ADD, 9990, 10000, 0), 1'b0, none});
		probes.push_back('{mk(CMD_QUERY, 0, 0, 0), 1'b0, none});
		probes.push_back('{mk(CMD_QUERY, 0, 0, 1), 1'b0, none});
		probes.push_back('{mk(CMD_QUERY, 0, 0, 500), 1'b0, none});
		probes.push_back('{mk(CMD_QUERY, 0, 0, 999), 1'b0, none});
		probes.push_back('{mk(CMD_QUERY, 0, 0, 1000), 1'b0, none});
		probes.push_back('{mk(CMD_QUERY, '1, '1, 1023), 1'b0, none});
		probes.push_back('{mk(CMD_UNUSED, 0, 0, 0), 1'b0, none});
		probes.push_back('{mk(CMD_CLEAR, '1, '1, '1), 1'b1, reset_view()});
		probes.push_back('{mk(CMD_QUERY, 0, 0, 1000), 1'b1, reset_view()});
		probes.push_back('{mk(CMD_ADD, 10005, 20000, 0), 1'b0, none});
		probes.push_back('{mk(CMD_QUERY, 0, 0, 1000), 1'b0, none});
		probes.push_back('{mk(CMD_CLEAR, 0, 0, 0), 1'b1, reset_view()});

		settings = '{NOM_RESET, 20'd0, 20'd1, 20'd1000, 20'd1000000, '1,
			NOM_W'($urandom_range(1000000, 1)), NOM_RESET};

		// Reset once, release on a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (probes[i]) begin
			pr = probes[i];
			send_item(pr.item, pr.typed, pr.want);
		end

		// Random phases, each at its own nominal period
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0)
				write_nominal(settings[ph]);
			calm = (ph == CALM_PHASE);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == HOLD_PHASE && n == PHASE_ITEMS / 2)
					drain();
				send_item(pick_item(), 1'b0, none);
			end
		end
		calm = 1'b0;

		// Wait out the remaining items, then the block's own latency
		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pjhm_pkg.sv
sv/period_jitter_histogram_monitor_core.sv
verif/tb_period_jitter_histogram_monitor_core.sv
